@@ rtl/core/sha256_stream_hasher_assert.svh @@
// Assertion macros used by the hasher RTL.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHS_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sha256 hasher: invariant violated");
`define SHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 hasher: sequence violated");
`else
`define SHS_ASSERT(label, cond)
`define SHS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/shs_pkg.sv @@
package shs_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // Working variables of the compression function.
    typedef struct packed
    {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } work_t;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] LAST_BYTE = 6'd63;
    localparam logic [5:0] LAST_RND  = 6'd63;
    localparam logic [2:0] LAST_IDX  = 3'd7;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

@@ rtl/core/shs_round.sv @@
module shs_round
(
    input  shs_pkg::work_t cur,
    input  logic [5:0]     rnd,
    input  logic [31:0]    w_t,
    input  logic [31:0]    w_1,
    input  logic [31:0]    w_9,
    input  logic [31:0]    w_14,
    output shs_pkg::work_t nxt,
    output logic [31:0]    w_new
);

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb
    begin
        ch  = (cur.e & cur.f) ^ (~cur.e & cur.g);
        maj = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
        t1  = cur.h + big_sigma1(cur.e) + ch + shs_pkg::ROUND_K[rnd] + w_t;
        t2  = big_sigma0(cur.a) + maj;

        nxt.a = t1 + t2;
        nxt.b = cur.a;
        nxt.c = cur.b;
        nxt.d = cur.c;
        nxt.e = cur.d + t1;
        nxt.f = cur.e;
        nxt.g = cur.f;
        nxt.h = cur.g;

        // Schedule word sixteen rounds ahead of the current one.
        w_new = w_t + small_sigma0(w_1) + w_9 + small_sigma1(w_14);
    end

endmodule

@@ rtl/core/sha256_stream_hasher.sv @@
// SHA-256 over a byte stream; one round of the compression function per cycle.
// A data byte is taken only while idle; a byte that completes a 64-byte block starts
// the rounds and the fold, and no byte is taken until they end. A finish word pads
// out the block (and a second one if the length does not fit), hashes each padded
// block, then gives eight digest words at one per cycle as the sink accepts them.
// Reset (rst_n low, asynchronous) loads the initial hash values and clears all counts.
module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

`include "sha256_stream_hasher_assert.svh"

    shs_pkg::state_t state_reg;
    shs_pkg::state_t state_next;

    logic [5:0]   cnt_reg;
    logic [60:0]  msg_reg;
    logic [511:0] buf_reg;
    logic [31:0]  hash_reg [8];
    shs_pkg::work_t work_reg;
    shs_pkg::work_t work_nxt;
    logic [5:0]   rnd_reg;
    logic         fin_reg;
    logic         pad_first_reg;
    logic         len_ok_reg;
    logic [63:0]  len_reg;
    logic [2:0]   idx_reg;

    logic         data_take;
    logic         fin_take;
    logic         byte_take;
    logic         len_phase;
    logic [7:0]   feed_byte;
    logic         out_take;
    logic [31:0]  w_new;
    shs_pkg::work_t hash_work;

    // The byte buffer doubles as the sixteen-word schedule window; word 0 sits at the top.
    shs_round u_round
    (
        .cur   (work_reg),
        .rnd   (rnd_reg),
        .w_t   (buf_reg[511:480]),
        .w_1   (buf_reg[479:448]),
        .w_9   (buf_reg[223:192]),
        .w_14  (buf_reg[63:32]),
        .nxt   (work_nxt),
        .w_new (w_new)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action)
                        state_next = shs_pkg::ST_PAD;
                    else if (cnt_reg == shs_pkg::LAST_BYTE)
                        state_next = shs_pkg::ST_ROUND;
                end
            end
            shs_pkg::ST_PAD:
            begin
                if (cnt_reg == shs_pkg::LAST_BYTE)
                    state_next = shs_pkg::ST_ROUND;
            end
            shs_pkg::ST_ROUND:
            begin
                if (rnd_reg == shs_pkg::LAST_RND)
                    state_next = shs_pkg::ST_FOLD;
            end
            shs_pkg::ST_FOLD:
            begin
                if (!fin_reg)
                    state_next = shs_pkg::ST_IDLE;
                else if (len_ok_reg)
                    state_next = shs_pkg::ST_EMIT;
                else
                    state_next = shs_pkg::ST_PAD;
            end
            shs_pkg::ST_EMIT:
            begin
                if (out_ready && idx_reg == shs_pkg::LAST_IDX)
                    state_next = shs_pkg::ST_IDLE;
            end
            default:
                state_next = shs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == shs_pkg::ST_IDLE);
        out_valid = (state_reg == shs_pkg::ST_EMIT);
        data_take = in_ready && in_valid && !action;
        fin_take  = in_ready && in_valid && action;
        out_take  = out_valid && out_ready;
        byte_take = data_take || (state_reg == shs_pkg::ST_PAD);
        // The length goes in the last eight bytes of the block that carries it.
        len_phase = (state_reg == shs_pkg::ST_PAD) && !pad_first_reg && len_ok_reg
                    && (cnt_reg >= shs_pkg::LEN_START);
        if (state_reg != shs_pkg::ST_PAD)
            feed_byte = data_byte;
        else if (pad_first_reg)
            feed_byte = shs_pkg::PAD_BYTE;
        else if (len_phase)
            feed_byte = len_reg[63:56];
        else
            feed_byte = 8'h00;
    end

    always_comb
    begin
        hash_work.a = hash_reg[0];
        hash_work.b = hash_reg[1];
        hash_work.c = hash_reg[2];
        hash_work.d = hash_reg[3];
        hash_work.e = hash_reg[4];
        hash_work.f = hash_reg[5];
        hash_work.g = hash_reg[6];
        hash_work.h = hash_reg[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= shs_pkg::ST_IDLE;
            cnt_reg       <= '0;
            msg_reg       <= '0;
            rnd_reg       <= '0;
            fin_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            idx_reg       <= '0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= shs_pkg::INIT_HASH[i];
        end
        else
        begin
            state_reg <= state_next;
            if (byte_take)
                cnt_reg <= cnt_reg + 6'd1;
            if (data_take)
                msg_reg <= msg_reg + 61'd1;
            if (fin_take)
            begin
                fin_reg       <= 1'b1;
                pad_first_reg <= 1'b1;
                len_ok_reg    <= (cnt_reg < shs_pkg::LEN_START);
            end
            if (state_reg == shs_pkg::ST_PAD)
                pad_first_reg <= 1'b0;
            if (state_reg == shs_pkg::ST_ROUND)
                rnd_reg <= rnd_reg + 6'd1;
            else
                rnd_reg <= '0;
            if (state_reg == shs_pkg::ST_FOLD)
            begin
                hash_reg[0] <= hash_reg[0] + work_reg.a;
                hash_reg[1] <= hash_reg[1] + work_reg.b;
                hash_reg[2] <= hash_reg[2] + work_reg.c;
                hash_reg[3] <= hash_reg[3] + work_reg.d;
                hash_reg[4] <= hash_reg[4] + work_reg.e;
                hash_reg[5] <= hash_reg[5] + work_reg.f;
                hash_reg[6] <= hash_reg[6] + work_reg.g;
                hash_reg[7] <= hash_reg[7] + work_reg.h;
                // A block without the length means a second padded block follows.
                if (fin_reg)
                    len_ok_reg <= 1'b1;
                idx_reg <= '0;
            end
            if (out_take)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == shs_pkg::LAST_IDX)
                begin
                    fin_reg <= 1'b0;
                    msg_reg <= '0;
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= shs_pkg::INIT_HASH[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_take)
            len_reg <= {msg_reg, 3'b000};
        else if (len_phase)
            len_reg <= {len_reg[55:0], 8'h00};

        if (byte_take)
            buf_reg <= {buf_reg[503:0], feed_byte};
        else if (state_reg == shs_pkg::ST_ROUND)
            buf_reg <= {buf_reg[479:0], w_new};

        if (byte_take && cnt_reg == shs_pkg::LAST_BYTE)
            work_reg <= hash_work;
        else if (state_reg == shs_pkg::ST_ROUND)
            work_reg <= work_nxt;
    end

    assign digest_word = hash_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == shs_pkg::LAST_IDX);

    `SHS_ASSERT(a_ready_excl_valid, !(in_ready && out_valid))
    `SHS_ASSERT(a_block_aligned, (state_reg == shs_pkg::ST_IDLE) || (state_reg == shs_pkg::ST_PAD) || (cnt_reg == 6'd0))
    `SHS_ASSERT_NEXT(a_round_to_fold, (state_reg == shs_pkg::ST_ROUND) && (rnd_reg == shs_pkg::LAST_RND), state_reg == shs_pkg::ST_FOLD)
    `SHS_ASSERT_NEXT(a_restart_clean, out_valid && out_ready && last_word, (msg_reg == 61'd0) && !fin_reg && in_ready)

endmodule
